@@ rtl/rgb_servo_pwm_mode_controller_macros.svh @@
`ifndef RGB_SERVO_PWM_MODE_CONTROLLER_MACROS_SVH
`define RGB_SERVO_PWM_MODE_CONTROLLER_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger.
`define RSP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Check that a condition holds in the cycle after its trigger.
`define RSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

@@ rtl/rsp_pkg.sv @@
`timescale 1ns / 1ps

package rsp_pkg;

    // Field and state widths
    localparam int PERIOD_W = 16;
    localparam int CMP_W    = 14;
    localparam int MODE_W   = 3;
    localparam int LEVEL_W  = 8;
    localparam int SERVO_W  = 7;
    localparam int PROD_W   = 24;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd24999;

    // Ticks a button must stay held before it reports hold
    localparam int HOLD_TICKS  = 100;
    // Steps in one turn of the hue wheel
    localparam int WHEEL_STEPS = 1440;

    // Mode codes as reported in the result item
    localparam logic [MODE_W-1:0] CODE_AUTO  = 3'd0;
    localparam logic [MODE_W-1:0] CODE_RED   = 3'd1;
    localparam logic [MODE_W-1:0] CODE_GREEN = 3'd2;
    localparam logic [MODE_W-1:0] CODE_BLUE  = 3'd3;
    localparam logic [MODE_W-1:0] CODE_SERVO = 3'd4;

    // Debouncer phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PRESS = 3'b010,
        PH_HELD  = 3'b100
    } phase_t;

    // Button event reported by a debouncer
    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_PRESS = 2'd1,
        EV_HOLD  = 2'd2
    } event_t;

    // Current levels, handed from the mode unit to the scaler
    typedef struct packed {
        logic [SERVO_W-1:0] servo;
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } levels_t;

endpackage

@@ rtl/rsp_debounce.sv @@
`timescale 1ns / 1ps

module rsp_debounce (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            down,
    output rsp_pkg::event_t evt
);
    import rsp_pkg::*;

    localparam int HOLD_W     = 7;

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [HOLD_W-1:0]   count_reg;
    logic [HOLD_W-1:0]   count_next;
    logic [HOLD_W-1:0]   count_sat;

    // Count up while held, stick at all ones
    assign count_sat = (count_reg == '1) ? count_reg : count_reg + 1'b1;

    // Advance the phase and report press or hold
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        evt        = EV_NONE;
        unique case (phase_reg)
            PH_PRESS:
            begin
                if (down)
                begin
                    phase_next = PH_HELD;
                    evt        = EV_PRESS;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_HELD:
            begin
                if (down)
                begin
                    count_next = count_sat;
                    if (count_sat > HOLD_W'(HOLD_TICKS))
                    begin
                        evt = EV_HOLD;
                    end
                end
                else
                begin
                    phase_next = PH_IDLE;
                    count_next = '0;
                end
            end
            default:
            begin
                phase_next = down ? PH_PRESS : PH_IDLE;
            end
        endcase
    end

    // Update on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
        end
        else if (en)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/rsp_mode_ctrl.sv @@
`timescale 1ns / 1ps

module rsp_mode_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         sw1,
    input  logic                         sw2,
    output logic                         lv_valid,
    input  logic                         lv_ready,
    output rsp_pkg::levels_t             levels,
    output logic [rsp_pkg::MODE_W-1:0]   mode_code
);
    import rsp_pkg::*;

    localparam int HUE_W       = 11;
    localparam int SPEED_W     = 8;
    localparam int SECTOR      = 240;
    localparam int LVL_HI      = 250;
    localparam int LVL_LO      = 10;
    localparam int MAN_MAX     = 240;
    localparam int MAN_STEP    = 10;
    localparam int SERVO_MIN   = 30;
    localparam int SERVO_MAX   = 120;
    localparam int SERVO_STEP  = 5;
    localparam int SPEED_MAX   = 255;

    typedef enum logic [4:0] {
        MODE_AUTO  = 5'b00001,
        MODE_RED   = 5'b00010,
        MODE_GREEN = 5'b00100,
        MODE_BLUE  = 5'b01000,
        MODE_SERVO = 5'b10000
    } mode_t;

    // Step a manual colour level by ten, increment first
    function automatic logic [LEVEL_W-1:0] step10(input logic [LEVEL_W-1:0] v,
                                                  input logic up, input logic dn);
        logic [LEVEL_W:0] t;
        t = {1'b0, v};
        if (up)
        begin
            t = t + (LEVEL_W+1)'(MAN_STEP);
            if (t > (LEVEL_W+1)'(MAN_MAX))
            begin
                t = (LEVEL_W+1)'(MAN_MAX);
            end
        end
        if (dn)
        begin
            t = (t < (LEVEL_W+1)'(2 * MAN_STEP)) ? (LEVEL_W+1)'(LVL_LO)
                                                 : t - (LEVEL_W+1)'(MAN_STEP);
        end
        return t[LEVEL_W-1:0];
    endfunction

    // Step the servo level by five within its range
    function automatic logic [SERVO_W-1:0] step5(input logic [SERVO_W-1:0] v,
                                                 input logic up, input logic dn);
        logic [SERVO_W-1:0] t;
        t = v;
        if (up)
        begin
            t = t + SERVO_W'(SERVO_STEP);
            if (t > SERVO_W'(SERVO_MAX))
            begin
                t = SERVO_W'(SERVO_MAX);
            end
        end
        if (dn)
        begin
            t = (t < SERVO_W'(SERVO_MIN + SERVO_STEP)) ? SERVO_W'(SERVO_MIN)
                                                       : t - SERVO_W'(SERVO_STEP);
        end
        return t;
    endfunction

    event_t               e1;
    event_t               e2;
    logic                 accept;
    logic                 lv_valid_reg;
    mode_t                mode_reg;
    mode_t                mode_next;
    logic                 blue_sel_reg;
    logic                 blue_sel_next;
    logic [SPEED_W-1:0]   speed_reg;
    logic [SPEED_W-1:0]   speed_next;
    logic [SPEED_W-1:0]   speed_inc;
    logic [SPEED_W-1:0]   speed_dec;
    logic [HUE_W-1:0]     hue_reg;
    logic [HUE_W-1:0]     hue_next;
    logic [HUE_W:0]       hue_sum;
    logic [HUE_W-1:0]     hue_wrap;
    logic [HUE_W-1:0]     hue_off;
    logic [LEVEL_W-1:0]   off_up;
    logic [LEVEL_W-1:0]   off_dn;
    levels_t              wheel_lv;
    levels_t              lv_reg;
    levels_t              lv_next;
    logic                 changed;
    logic                 p1;
    logic                 p2;

    // Debounce both buttons
    rsp_debounce u_deb1 (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (accept),
        .down  (sw1),
        .evt   (e1)
    );

    rsp_debounce u_deb2 (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (accept),
        .down  (sw2),
        .evt   (e2)
    );

    // Take an item whenever the level stage is empty or moving on
    assign in_ready = !lv_valid_reg || lv_ready;
    assign accept   = in_valid && in_ready;
    assign p1       = (e1 == EV_PRESS);
    assign p2       = (e2 == EV_PRESS);

    // Adjust wheel speed: raise to 255, lower to 1
    assign speed_inc = (p1 && speed_reg != SPEED_W'(SPEED_MAX)) ? speed_reg + 1'b1 : speed_reg;
    assign speed_dec = !p2 ? speed_inc
                     : (speed_inc > SPEED_W'(1)) ? speed_inc - 1'b1 : SPEED_W'(1);

    // Advance the hue and wrap once
    assign hue_sum  = {1'b0, hue_reg} + (HUE_W+1)'(speed_dec);
    assign hue_wrap = (hue_sum >= (HUE_W+1)'(WHEEL_STEPS))
                    ? HUE_W'(hue_sum - (HUE_W+1)'(WHEEL_STEPS)) : hue_sum[HUE_W-1:0];

    // Map the hue into six sectors
    always_comb
    begin
        wheel_lv       = lv_reg;
        hue_off        = hue_wrap;
        priority if (hue_wrap < HUE_W'(SECTOR))
        begin
            hue_off = hue_wrap;
        end
        else if (hue_wrap < HUE_W'(2 * SECTOR))
        begin
            hue_off = hue_wrap - HUE_W'(SECTOR);
        end
        else if (hue_wrap < HUE_W'(3 * SECTOR))
        begin
            hue_off = hue_wrap - HUE_W'(2 * SECTOR);
        end
        else if (hue_wrap < HUE_W'(4 * SECTOR))
        begin
            hue_off = hue_wrap - HUE_W'(3 * SECTOR);
        end
        else if (hue_wrap < HUE_W'(5 * SECTOR))
        begin
            hue_off = hue_wrap - HUE_W'(4 * SECTOR);
        end
        else
        begin
            hue_off = hue_wrap - HUE_W'(5 * SECTOR);
        end
        off_up = LEVEL_W'(LVL_LO) + hue_off[LEVEL_W-1:0];
        off_dn = LEVEL_W'(LVL_HI) - hue_off[LEVEL_W-1:0];
        priority if (hue_wrap < HUE_W'(SECTOR))
        begin
            wheel_lv.red   = LEVEL_W'(LVL_HI);
            wheel_lv.green = off_up;
            wheel_lv.blue  = LEVEL_W'(LVL_LO);
        end
        else if (hue_wrap < HUE_W'(2 * SECTOR))
        begin
            wheel_lv.red   = off_dn;
            wheel_lv.green = LEVEL_W'(LVL_HI);
            wheel_lv.blue  = LEVEL_W'(LVL_LO);
        end
        else if (hue_wrap < HUE_W'(3 * SECTOR))
        begin
            wheel_lv.red   = LEVEL_W'(LVL_LO);
            wheel_lv.green = LEVEL_W'(LVL_HI);
            wheel_lv.blue  = off_up;
        end
        else if (hue_wrap < HUE_W'(4 * SECTOR))
        begin
            wheel_lv.red   = LEVEL_W'(LVL_LO);
            wheel_lv.green = off_dn;
            wheel_lv.blue  = LEVEL_W'(LVL_HI);
        end
        else if (hue_wrap < HUE_W'(5 * SECTOR))
        begin
            wheel_lv.red   = off_up;
            wheel_lv.green = LEVEL_W'(LVL_LO);
            wheel_lv.blue  = LEVEL_W'(LVL_HI);
        end
        else
        begin
            wheel_lv.red   = LEVEL_W'(LVL_HI);
            wheel_lv.green = LEVEL_W'(LVL_LO);
            wheel_lv.blue  = off_dn;
        end
    end

    // Select a mode or act on the current one
    always_comb
    begin
        mode_next     = mode_reg;
        blue_sel_next = blue_sel_reg;
        speed_next    = speed_reg;
        hue_next      = hue_reg;
        lv_next       = lv_reg;
        changed       = 1'b0;
        priority if (e2 != EV_HOLD)
        begin
            blue_sel_next = 1'b0;
        end
        else if (e1 == EV_PRESS)
        begin
            mode_next     = blue_sel_reg ? MODE_BLUE : MODE_RED;
            blue_sel_next = 1'b1;
            changed       = 1'b1;
        end
        else if (e1 == EV_HOLD)
        begin
            mode_next = MODE_GREEN;
            changed   = 1'b1;
        end
        if (!changed)
        begin
            unique case (mode_reg)
                MODE_AUTO:
                begin
                    speed_next     = speed_dec;
                    hue_next       = hue_wrap;
                    lv_next.red    = wheel_lv.red;
                    lv_next.green  = wheel_lv.green;
                    lv_next.blue   = wheel_lv.blue;
                end
                MODE_RED:
                begin
                    lv_next.green = LEVEL_W'(LVL_LO);
                    lv_next.blue  = LEVEL_W'(LVL_LO);
                    lv_next.red   = step10(lv_reg.red, p1, p2);
                end
                MODE_GREEN:
                begin
                    lv_next.red   = LEVEL_W'(LVL_LO);
                    lv_next.blue  = LEVEL_W'(LVL_LO);
                    lv_next.green = step10(lv_reg.green, p1, p2);
                end
                MODE_BLUE:
                begin
                    lv_next.red   = LEVEL_W'(LVL_LO);
                    lv_next.green = LEVEL_W'(LVL_LO);
                    lv_next.blue  = step10(lv_reg.blue, p1, p2);
                end
                default:
                begin
                    lv_next.servo = step5(lv_reg.servo, p1, p2);
                    lv_next.red   = LEVEL_W'(1);
                    lv_next.green = LEVEL_W'(1);
                    lv_next.blue  = LEVEL_W'(1);
                end
            endcase
        end
    end

    // Hold state; the state registers double as the level stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_SERVO;
            blue_sel_reg <= 1'b0;
            speed_reg    <= SPEED_W'(2);
            hue_reg      <= '0;
            lv_reg.servo <= SERVO_W'(75);
            lv_reg.red   <= LEVEL_W'(1);
            lv_reg.green <= LEVEL_W'(1);
            lv_reg.blue  <= LEVEL_W'(1);
            lv_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg     <= mode_next;
                blue_sel_reg <= blue_sel_next;
                speed_reg    <= speed_next;
                hue_reg      <= hue_next;
                lv_reg       <= lv_next;
            end
            if (in_ready)
            begin
                lv_valid_reg <= accept;
            end
        end
    end

    // Encode the mode for the result
    always_comb
    begin
        unique case (mode_reg)
            MODE_AUTO:  mode_code = CODE_AUTO;
            MODE_RED:   mode_code = CODE_RED;
            MODE_GREEN: mode_code = CODE_GREEN;
            MODE_BLUE:  mode_code = CODE_BLUE;
            default:    mode_code = CODE_SERVO;
        endcase
    end

    assign levels   = lv_reg;
    assign lv_valid = lv_valid_reg;

endmodule

@@ rtl/rsp_scale.sv @@
`timescale 1ns / 1ps

module rsp_scale (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  rsp_pkg::levels_t               levels,
    input  logic [rsp_pkg::MODE_W-1:0]     mode_in,
    input  logic [rsp_pkg::PERIOD_W-1:0]   period,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rsp_pkg::CMP_W-1:0]      servo_cmp,
    output logic [rsp_pkg::CMP_W-1:0]      red_cmp,
    output logic [rsp_pkg::CMP_W-1:0]      blue_cmp,
    output logic [rsp_pkg::CMP_W-1:0]      green_cmp,
    output logic [rsp_pkg::MODE_W-1:0]     mode_out
);
    import rsp_pkg::*;

    // ceil(2^34 / 1000): exact quotient for any 24-bit product
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 34;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 25'd17179870;
    localparam int WIDE_W      = PROD_W + RECIP_W;

    // Divide a product by 1000, keep the low compare bits
    function automatic logic [CMP_W-1:0] div1000(input logic [PROD_W-1:0] p);
        logic [WIDE_W-1:0] t;
        t = WIDE_W'(p) * WIDE_W'(RECIP_1000);
        return t[RECIP_SHIFT+CMP_W-1:RECIP_SHIFT];
    endfunction

    logic                 prod_valid_reg;
    logic                 prod_ready;
    logic [PROD_W-1:0]    servo_prod_reg;
    logic [PROD_W-1:0]    red_prod_reg;
    logic [PROD_W-1:0]    blue_prod_reg;
    logic [PROD_W-1:0]    green_prod_reg;
    logic [MODE_W-1:0]    prod_mode_reg;
    logic                 out_valid_reg;
    logic                 out_load;
    logic [CMP_W-1:0]     servo_cmp_reg;
    logic [CMP_W-1:0]     red_cmp_reg;
    logic [CMP_W-1:0]     blue_cmp_reg;
    logic [CMP_W-1:0]     green_cmp_reg;
    logic [MODE_W-1:0]    mode_out_reg;

    // Each stage moves on when the one after it has room
    assign out_load   = !out_valid_reg || out_ready;
    assign prod_ready = !prod_valid_reg || out_load;
    assign in_ready   = prod_ready;

    // Multiply levels by the period
    always_ff @(posedge clk)
    begin
        if (prod_ready)
        begin
            servo_prod_reg <= PROD_W'(levels.servo) * PROD_W'(period);
            red_prod_reg   <= PROD_W'(levels.red) * PROD_W'(period);
            blue_prod_reg  <= PROD_W'(levels.blue) * PROD_W'(period);
            green_prod_reg <= PROD_W'(levels.green) * PROD_W'(period);
            prod_mode_reg  <= mode_in;
        end
    end

    // Divide by 1000 into the result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            servo_cmp_reg <= div1000(servo_prod_reg);
            red_cmp_reg   <= div1000(red_prod_reg);
            blue_cmp_reg  <= div1000(blue_prod_reg);
            green_cmp_reg <= div1000(green_prod_reg);
            mode_out_reg  <= prod_mode_reg;
        end
    end

    // Track stage occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_ready)
            begin
                prod_valid_reg <= in_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign servo_cmp = servo_cmp_reg;
    assign red_cmp   = red_cmp_reg;
    assign blue_cmp  = blue_cmp_reg;
    assign green_cmp = green_cmp_reg;
    assign mode_out  = mode_out_reg;

endmodule

@@ rtl/rgb_servo_pwm_mode_controller.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake                  Payload
// s_*      in         s_tvalid / s_tready        s_tdata: sw1_pressed, sw2_pressed
// m_*      out        m_tvalid / m_tready        m_tdata: four compares, current_mode
// cfg_*    in         cfg_valid / cfg_ready      cfg_data: pwm_period
//
// One item per clock sustained while m_tready is high; each passes the level
// register, then the two multiply stages (level times period, then the
// reciprocal of 1000), before its result shows on m_tvalid. Mode and debounce
// state update at the accepting edge. rst_n is asynchronous and returns all
// control and valid state to its power-on values, but not the scaler data
// registers. With m_tready low the three stages fill, then s_tready drops; cfg_ready is always high.

module rgb_servo_pwm_mode_controller (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [0] sw1_pressed, [1] sw2_pressed
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [63:0]                    m_tdata,   // [13:0] servo_compare,
                                                      // [27:14] red_compare,
                                                      // [41:28] blue_compare,
                                                      // [55:42] green_compare,
                                                      // [58:56] current_mode
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rsp_pkg::PERIOD_W-1:0]   cfg_data
);
    import rsp_pkg::*;

    logic [PERIOD_W-1:0]  period_reg;
    logic                 lv_valid;
    logic                 lv_ready;
    levels_t              levels;
    logic [MODE_W-1:0]    mode_code;
    logic [CMP_W-1:0]     servo_cmp;
    logic [CMP_W-1:0]     red_cmp;
    logic [CMP_W-1:0]     blue_cmp;
    logic [CMP_W-1:0]     green_cmp;
    logic [MODE_W-1:0]    mode_out;

    // Hold the PWM period
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            period_reg <= cfg_data;
        end
    end

    // Debounce, select mode, update levels
    rsp_mode_ctrl u_mode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .sw1       (s_tdata[0]),
        .sw2       (s_tdata[1]),
        .lv_valid  (lv_valid),
        .lv_ready  (lv_ready),
        .levels    (levels),
        .mode_code (mode_code)
    );

    // Scale levels into compare values
    rsp_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lv_valid),
        .in_ready  (lv_ready),
        .levels    (levels),
        .mode_in   (mode_code),
        .period    (period_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .servo_cmp (servo_cmp),
        .red_cmp   (red_cmp),
        .blue_cmp  (blue_cmp),
        .green_cmp (green_cmp),
        .mode_out  (mode_out)
    );

    // Pack the result item
    assign m_tdata = {5'b0, mode_out, green_cmp, blue_cmp, red_cmp, servo_cmp};

endmodule

@@ rtl/rsp_checker.sv @@
`timescale 1ns / 1ps

`include "rgb_servo_pwm_mode_controller_macros.svh"

module rsp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata
);

    // Stalled result holds
    `RSP_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Empty result register means the input side takes items
    `RSP_ASSERT_SAME(a_in_open, clk, rst_n, !m_tvalid, s_tready)

    // Mode code stays within auto, manual and servo
    `RSP_ASSERT_SAME(a_mode_range, clk, rst_n, m_tvalid, m_tdata[58:56] <= 3'd4)

    // Padding above the fields is zero
    `RSP_ASSERT_SAME(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[63:59] == 5'd0)

endmodule

bind rgb_servo_pwm_mode_controller rsp_checker u_rsp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/sv/tb_rgb_servo_pwm_mode_controller.sv @@
`timescale 1ns / 1ps

module tb_rgb_servo_pwm_mode_controller;

    import rsp_pkg::*;

    localparam int LONG_STALL     = 60;
    localparam int WATCHDOG_LIMIT = 2000;

    // Button script for the directed part, one {sw2, sw1} pair per tick, first tick leftmost
    localparam int DIRECTED_N = 20;
    localparam logic [2*DIRECTED_N-1:0] DIRECTED_TICKS = {
        2'b00, 2'b01, 2'b00, 2'b11, 2'b11, 2'b11, 2'b10, 2'b00, 2'b01, 2'b01,
        2'b00, 2'b10, 2'b10, 2'b10, 2'b00, 2'b01, 2'b01, 2'b11, 2'b11, 2'b00
    };

    typedef enum logic [2:0] {
        MODE_AUTO  = CODE_AUTO,
        MODE_RED   = CODE_RED,
        MODE_GREEN = CODE_GREEN,
        MODE_BLUE  = CODE_BLUE,
        MODE_SERVO = CODE_SERVO
    } mode_t;

    typedef struct {
        logic [CMP_W-1:0] servo;
        logic [CMP_W-1:0] red;
        logic [CMP_W-1:0] blue;
        logic [CMP_W-1:0] green;
        logic [2:0]       mode;
    } compare_set_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata   = 8'd0;   // [0] sw1_pressed, [1] sw2_pressed
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [63:0]         m_tdata;            // servo, red, blue, green compares, mode
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [PERIOD_W-1:0] cfg_data  = '0;

    // Predicted controller state
    logic [PERIOD_W-1:0] pwm_period;
    phase_t              btn_phase [2];
    logic [6:0]          btn_hold  [2];
    mode_t               mode_now;
    logic                blue_next;
    logic [7:0]          wheel_speed;
    logic [10:0]         hue_angle;
    logic [7:0]          red_lvl;
    logic [7:0]          green_lvl;
    logic [7:0]          blue_lvl;
    logic [6:0]          servo_lvl;

    compare_set_t pending_compares [$];

    int  mismatches     = 0;
    int  ticks_sent     = 0;
    int  mode_changes   = 0;
    int  quiet_cycles   = 0;
    int  stall_requests = 0;
    int  stalls_served  = 0;
    int  stall_left     = 0;
    int  snk_gap_left   = 0;
    bit  src_idle_on    = 1'b1;
    bit  snk_idle_on    = 1'b1;

    rgb_servo_pwm_mode_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Return the controller model to its power-on state
    function automatic void reset_controller();
        pwm_period  = PERIOD_RESET;
        btn_phase   = '{PH_IDLE, PH_IDLE};
        btn_hold    = '{7'd0, 7'd0};
        mode_now    = MODE_SERVO;
        blue_next   = 1'b0;
        wheel_speed = 8'd2;
        hue_angle   = 11'd0;
        red_lvl     = 8'd1;
        green_lvl   = 8'd1;
        blue_lvl    = 8'd1;
        servo_lvl   = 7'd75;
    endfunction

    // Advance one debouncer and report its event
    function automatic event_t debounce_button(input int k, input logic down);
        event_t ev;
        ev = EV_NONE;
        case (btn_phase[k])
            PH_PRESS:
            begin
                if (down)
                begin
                    btn_phase[k] = PH_HELD;
                    ev = EV_PRESS;
                end
                else
                begin
                    btn_phase[k] = PH_IDLE;
                end
            end
            PH_HELD:
            begin
                if (down)
                begin
                    if (btn_hold[k] < 7'd127)
                        btn_hold[k] = btn_hold[k] + 7'd1;
                    if (btn_hold[k] > HOLD_TICKS)
                        ev = EV_HOLD;
                end
                else
                begin
                    btn_phase[k] = PH_IDLE;
                    btn_hold[k]  = 7'd0;
                end
            end
            default:
            begin
                btn_phase[k] = down ? PH_PRESS : PH_IDLE;
            end
        endcase
        return ev;
    endfunction

    // Step a manual colour level: increment first, then decrement
    function automatic logic [7:0] bump_level(input logic [7:0] lvl, input event_t e1,
                                              input event_t e2);
        if (e1 == EV_PRESS)
            lvl = ({1'b0, lvl} + 9'd10 > 9'd240) ? 8'd240 : lvl + 8'd10;
        if (e2 == EV_PRESS)
            lvl = (lvl < 8'd20) ? 8'd10 : lvl - 8'd10;
        return lvl;
    endfunction

    function automatic logic [CMP_W-1:0] to_compare(input logic [7:0] lvl);
        logic [23:0] product;
        product = {16'd0, lvl} * {8'd0, pwm_period};
        return CMP_W'(product / 24'd1000);
    endfunction

    // Apply one button tick to the model and form the compare set it yields
    task automatic advance_controller(input logic sw1, input logic sw2,
                                      output compare_set_t res);
        event_t      e1;
        event_t      e2;
        logic        changed;
        int          sector;
        logic [7:0]  offset;
        e1 = debounce_button(0, sw1);
        e2 = debounce_button(1, sw2);
        changed = 1'b0;

        // Mode selection takes priority over the mode action
        if (e2 != EV_HOLD)
        begin
            blue_next = 1'b0;
        end
        else if (e1 == EV_PRESS)
        begin
            mode_now  = blue_next ? MODE_BLUE : MODE_RED;
            blue_next = 1'b1;
            changed   = 1'b1;
        end
        else if (e1 == EV_HOLD)
        begin
            mode_now = MODE_GREEN;
            changed  = 1'b1;
        end
        if (changed)
            mode_changes++;

        if (!changed)
        begin
            case (mode_now)
                MODE_AUTO:
                begin
                    if (e1 == EV_PRESS && wheel_speed != 8'd255)
                        wheel_speed = wheel_speed + 8'd1;
                    if (e2 == EV_PRESS && wheel_speed > 8'd1)
                        wheel_speed = wheel_speed - 8'd1;
                    hue_angle = hue_angle + {3'd0, wheel_speed};
                    if (hue_angle >= 11'd1440)
                        hue_angle = hue_angle - 11'd1440;
                    sector = hue_angle / 240;
                    offset = 8'(hue_angle - sector * 240);
                    case (sector)
                        0:
                        begin
                            green_lvl = 8'd10 + offset; red_lvl = 8'd250; blue_lvl = 8'd10;
                        end
                        1:
                        begin
                            red_lvl = 8'd250 - offset; green_lvl = 8'd250; blue_lvl = 8'd10;
                        end
                        2:
                        begin
                            blue_lvl = 8'd10 + offset; green_lvl = 8'd250; red_lvl = 8'd10;
                        end
                        3:
                        begin
                            green_lvl = 8'd250 - offset; blue_lvl = 8'd250; red_lvl = 8'd10;
                        end
                        4:
                        begin
                            red_lvl = 8'd10 + offset; blue_lvl = 8'd250; green_lvl = 8'd10;
                        end
                        default:
                        begin
                            blue_lvl = 8'd250 - offset; red_lvl = 8'd250; green_lvl = 8'd10;
                        end
                    endcase
                end
                MODE_RED:
                begin
                    green_lvl = 8'd10;
                    blue_lvl  = 8'd10;
                    red_lvl   = bump_level(red_lvl, e1, e2);
                end
                MODE_GREEN:
                begin
                    red_lvl   = 8'd10;
                    blue_lvl  = 8'd10;
                    green_lvl = bump_level(green_lvl, e1, e2);
                end
                MODE_BLUE:
                begin
                    red_lvl   = 8'd10;
                    green_lvl = 8'd10;
                    blue_lvl  = bump_level(blue_lvl, e1, e2);
                end
                default:
                begin
                    if (e1 == EV_PRESS)
                        servo_lvl = (servo_lvl + 7'd5 > 7'd120) ? 7'd120 : servo_lvl + 7'd5;
                    if (e2 == EV_PRESS)
                        servo_lvl = (servo_lvl < 7'd35) ? 7'd30 : servo_lvl - 7'd5;
                    red_lvl   = 8'd1;
                    green_lvl = 8'd1;
                    blue_lvl  = 8'd1;
                end
            endcase
        end

        res.servo = to_compare({1'b0, servo_lvl});
        res.red   = to_compare(red_lvl);
        res.blue  = to_compare(blue_lvl);
        res.green = to_compare(green_lvl);
        res.mode  = mode_now;
    endtask

    // Offer one tick, wait for it to be taken, and queue its expected compare set
    task automatic send_tick(input logic sw1, input logic sw2);
        int           gap;
        compare_set_t res;
        if (src_idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, sw2, sw1};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        advance_controller(sw1, sw2, res);
        pending_compares.push_back(res);
        ticks_sent++;
    endtask

    // Press the chosen buttons long enough for a press event, then release
    task automatic tap(input logic sw1, input logic sw2);
        repeat ($urandom_range(2, 3)) send_tick(sw1, sw2);
        repeat ($urandom_range(1, 2)) send_tick(1'b0, 1'b0);
    endtask

    // Stop offering and let every outstanding compare set arrive
    task automatic drain_results(input int settle);
        s_tvalid <= 1'b0;
        while (pending_compares.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] value);
        drain_results(4);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        pwm_period = value;
    endtask

    // Short presses, single-tick glitches and simultaneous presses in servo mode
    task automatic test_directed_ticks();
        for (int i = 0; i < DIRECTED_N; i++)
            send_tick(DIRECTED_TICKS[2*(DIRECTED_N-1-i)], DIRECTED_TICKS[2*(DIRECTED_N-1-i)+1]);
    endtask

    // Drive the servo level into its upper clamp, then down into the lower one
    task automatic test_servo_limits();
        int pick;
        for (int i = 0; i < 32; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 8)
                tap(1'b1, 1'b1);
            else if ((pick < 8) == (i < 12))
                tap(1'b1, 1'b0);
            else
                tap(1'b0, 1'b1);
        end
    endtask

    // Hold the second button past the hold threshold while the first one taps or holds
    task automatic test_mode_select(input bit settle_green);
        int   hold_len;
        int   sw1_from;
        int   cycle_ofs;
        logic sw1;
        hold_len  = $urandom_range(106, 135);
        sw1_from  = settle_green ? $urandom_range(1, hold_len - 104) : hold_len;
        cycle_ofs = $urandom_range(0, 2);
        for (int i = 0; i < hold_len; i++)
        begin
            if (i >= sw1_from)
                sw1 = 1'b1;
            else if (i >= HOLD_TICKS + 2)
                sw1 = ((i + cycle_ofs) % 3) != 0;
            else
                sw1 = 1'($urandom_range(0, 1));
            send_tick(sw1, 1'b1);
        end
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
    endtask

    // Random button levels while the output side holds off for a long stretch
    task automatic test_button_noise(input int count);
        src_idle_on = 1'b0;
        stall_requests++;
        repeat (count) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        src_idle_on = 1'b1;
    endtask

    initial
    begin
        reset_controller();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_ticks();
        write_period(16'hFFFF);
        test_servo_limits();
        write_period(16'($urandom_range(2, 65534)));
        test_mode_select(1'b0);
        write_period(16'd1);
        test_button_noise(60);
        write_period(16'd1000);
        test_mode_select(1'b1);

        // Finish without any idling on either side
        write_period(16'($urandom_range(2, 65534)));
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        test_mode_select(1'($urandom_range(0, 1)));

        drain_results(8);
        $display("Covered %0d button ticks across six period settings in servo and manual modes,",
                 ticks_sent);
        $display("with %0d mode changes, one long output stall and %0d mismatches.",
                 mode_changes, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Output side: random stall bursts, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (stalls_served != stall_requests)
        begin
            m_tready      <= 1'b0;
            stalls_served <= stall_requests;
            stall_left    <= LONG_STALL;
        end
        else if (snk_gap_left > 0)
        begin
            m_tready     <= 1'b0;
            snk_gap_left <= snk_gap_left - 1;
        end
        else if (snk_idle_on && $urandom_range(0, 5) == 0)
        begin
            m_tready     <= 1'b0;
            snk_gap_left <= $urandom_range(0, 16);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input logic [CMP_W-1:0] expv,
                                        input logic [CMP_W-1:0] actv);
        if (actv !== expv)
        begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            mismatches++;
        end
    endfunction

    // Compare each delivered item against the oldest expectation
    always @(posedge clk)
    begin : check_results
        compare_set_t expv;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_compares.size() == 0)
            begin
                $error("compare set delivered with none expected: %h", m_tdata);
                mismatches++;
            end
            else
            begin
                expv = pending_compares.pop_front();
                check_field("servo_compare", expv.servo, m_tdata[13:0]);
                check_field("red_compare", expv.red, m_tdata[27:14]);
                check_field("blue_compare", expv.blue, m_tdata[41:28]);
                check_field("green_compare", expv.green, m_tdata[55:42]);
                check_field("current_mode", {11'd0, expv.mode}, {11'd0, m_tdata[58:56]});
            end
        end
    end

    // Abort when no channel has moved an item for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/rsp_pkg.sv
rtl/rsp_debounce.sv
rtl/rsp_mode_ctrl.sv
rtl/rsp_scale.sv
rtl/rgb_servo_pwm_mode_controller.sv
rtl/rsp_checker.sv
tb/sv/tb_rgb_servo_pwm_mode_controller.sv
